### rtl/core/indexed_shift_array_macros.svh
// ----------------------------------------------------------------------------
// indexed_shift_array assertion macros
// Clocked assertion shorthands, gated off while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef INDEXED_SHIFT_ARRAY_MACROS_SVH
`define INDEXED_SHIFT_ARRAY_MACROS_SVH

// same-cycle implication
`define ISA_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ISA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/isa_pkg.sv
// ----------------------------------------------------------------------------
// isa_pkg
// Shared types and defaults for the indexed shift array.
// ----------------------------------------------------------------------------
package isa_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int POS_WIDTH_DEF  = $clog2(DEPTH_DEF + 1);

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_APPEND = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic read_en;
    } cmd_t;

endpackage

### rtl/core/isa_req_if.sv
// ----------------------------------------------------------------------------
// isa_req_if
// Request channel: valid/ready handshake carrying one request transaction.
// ----------------------------------------------------------------------------
interface isa_req_if #(
    parameter int DATA_WIDTH = isa_pkg::DATA_WIDTH_DEF,
    parameter int POS_WIDTH  = isa_pkg::POS_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [POS_WIDTH-1:0]  position;
    logic [DATA_WIDTH-1:0] value;

    modport source (output valid, output kind, output position, output value, input ready);
    modport sink   (input valid, input kind, input position, input value, output ready);
endinterface

### rtl/core/isa_rsp_if.sv
// ----------------------------------------------------------------------------
// isa_rsp_if
// Response channel: valid/ready handshake carrying one result transaction.
// ----------------------------------------------------------------------------
interface isa_rsp_if #(
    parameter int DATA_WIDTH = isa_pkg::DATA_WIDTH_DEF,
    parameter int POS_WIDTH  = isa_pkg::POS_WIDTH_DEF
);
    logic                  valid;
    logic                  ready;
    logic [DATA_WIDTH-1:0] read_value;
    logic [POS_WIDTH-1:0]  entry_count;
    logic [DATA_WIDTH-1:0] front_value;
    logic [DATA_WIDTH-1:0] back_value;
    logic                  empty_res;
    logic [1:0]            status;

    modport source (output valid, output read_value, output entry_count, output front_value,
                    output back_value, output empty_res, output status, input ready);
    modport sink   (input valid, input read_value, input entry_count, input front_value,
                    input back_value, input empty_res, input status, output ready);
endinterface

### rtl/core/isa_cell.sv
// ----------------------------------------------------------------------------
// isa_cell
// One storage cell of the row: holds a word, shifts to/from its neighbours.
// ----------------------------------------------------------------------------
module isa_cell #(
    parameter int DATA_WIDTH = isa_pkg::DATA_WIDTH_DEF,
    parameter int POS_WIDTH  = isa_pkg::POS_WIDTH_DEF,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  isa_pkg::cmd_t         cmd,
    input  logic [POS_WIDTH-1:0]  shift_pos,
    input  logic [POS_WIDTH-1:0]  held_next,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic [DATA_WIDTH-1:0] rd_in,
    input  logic [DATA_WIDTH-1:0] bk_in,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] data_nx,
    output logic [DATA_WIDTH-1:0] rd_out,
    output logic [DATA_WIDTH-1:0] bk_out
);

    localparam logic [POS_WIDTH-1:0] IDX      = POS_WIDTH'(INDEX);
    localparam logic [POS_WIDTH-1:0] IDX_NEXT = POS_WIDTH'(INDEX + 1);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.shift_up)
        begin
            if (IDX == shift_pos)
            begin
                data_next = value;
            end
            else if (IDX > shift_pos)
            begin
                data_next = left_data;
            end
        end
        else if (cmd.shift_down)
        begin
            if (IDX >= shift_pos)
            begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign data_nx = data_next;
    assign rd_out  = rd_in | ((cmd.read_en && (IDX == shift_pos)) ? data_reg : '0);
    assign bk_out  = bk_in | ((IDX_NEXT == held_next) ? data_next : '0);

endmodule

### rtl/core/isa_ctrl.sv
// ----------------------------------------------------------------------------
// isa_ctrl
// Request decode, range/full checks and the entry count register.
// ----------------------------------------------------------------------------
`include "indexed_shift_array_macros.svh"

module isa_ctrl #(
    parameter int DEPTH     = isa_pkg::DEPTH_DEF,
    parameter int POS_WIDTH = isa_pkg::POS_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic [1:0]           kind,
    input  logic [POS_WIDTH-1:0] position,
    output isa_pkg::cmd_t        cmd,
    output logic [POS_WIDTH-1:0] shift_pos,
    output logic [POS_WIDTH-1:0] held_next,
    output isa_pkg::status_t     status
);

    localparam logic [POS_WIDTH-1:0] FULL_COUNT = POS_WIDTH'(DEPTH);
    localparam logic [POS_WIDTH-1:0] ONE        = POS_WIDTH'(1);

    logic [POS_WIDTH-1:0] held_reg;
    logic [POS_WIDTH-1:0] held_upd;
    logic                 full;

    assign full = (held_reg == FULL_COUNT);

    always_comb
    begin
        cmd       = '0;
        shift_pos = position;
        status    = isa_pkg::STATUS_OK;
        held_upd  = held_reg;
        case (isa_pkg::kind_t'(kind))
            isa_pkg::KIND_INSERT:
            begin
                if (full)
                begin
                    status = isa_pkg::STATUS_FULL;
                end
                else if (position > held_reg)
                begin
                    status = isa_pkg::STATUS_RANGE;
                end
                else
                begin
                    cmd.shift_up = 1'b1;
                    held_upd     = held_reg + ONE;
                end
            end
            isa_pkg::KIND_REMOVE:
            begin
                if (position >= held_reg)
                begin
                    status = isa_pkg::STATUS_RANGE;
                end
                else
                begin
                    cmd.shift_down = 1'b1;
                    cmd.read_en    = 1'b1;
                    held_upd       = held_reg - ONE;
                end
            end
            isa_pkg::KIND_READ:
            begin
                if (position >= held_reg)
                begin
                    status = isa_pkg::STATUS_RANGE;
                end
                else
                begin
                    cmd.read_en = 1'b1;
                end
            end
            default:
            begin
                shift_pos = held_reg;
                if (full)
                begin
                    status = isa_pkg::STATUS_FULL;
                end
                else
                begin
                    cmd.shift_up = 1'b1;
                    held_upd     = held_reg + ONE;
                end
            end
        endcase
        if (!fire)
        begin
            cmd      = '0;
            held_upd = held_reg;
        end
    end

    assign held_next = held_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_upd;
        end
    end

    `ISA_ASSERT(a_held_bound, 1'b1, held_reg <= FULL_COUNT, "entry count above capacity")
    `ISA_ASSERT(a_reject_keeps, status != isa_pkg::STATUS_OK, held_next == held_reg, "rejected request changed count")
    `ISA_ASSERT(a_one_shift, 1'b1, $onehot0({cmd.shift_up, cmd.shift_down}), "shift up and down together")
    `ISA_ASSERT_NXT(a_idle_keeps, !fire, held_reg == $past(held_reg), "count moved without a transaction")

endmodule

### rtl/core/indexed_shift_array.sv
// ----------------------------------------------------------------------------
// indexed_shift_array
// Fixed-capacity ordered word list with insert, remove, read and append.
// ----------------------------------------------------------------------------
// Requests arrive on req (kind, position, value); each accepted transaction
// yields exactly one result transaction on rsp carrying the value read or
// removed, the entry count, front and back entries, an empty flag and status.
// The entries sit in a row of DEPTH cells; those at and above the position
// all shift by one in the same cycle. Results appear on rsp the cycle after
// acceptance; one transaction per cycle is sustained unless rsp stalls.
// The rsp register decouples the two sides: req.ready stays high while rsp is
// empty or being taken, so a new request is accepted in the same cycle the
// previous result leaves. While rsp is stalled, req.ready is low and the
// pending result holds. Reset empties the list (count zero) and drops any
// pending result; stored words are not cleared and are never visible
// until written. Out-of-range positions and inserts into a full list are
// reported in status and leave the list untouched.
// ----------------------------------------------------------------------------
`include "indexed_shift_array_macros.svh"

module indexed_shift_array #(
    parameter int DEPTH      = isa_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = isa_pkg::DATA_WIDTH_DEF,
    parameter int POS_WIDTH  = $clog2(DEPTH + 1)
) (
    input logic      clk,
    input logic      rst_n,
    isa_req_if.sink  req,
    isa_rsp_if.source rsp
);

    isa_pkg::cmd_t          cmd;
    isa_pkg::status_t       status;
    logic [POS_WIDTH-1:0]   shift_pos;
    logic [POS_WIDTH-1:0]   held_next;
    logic                   fire;

    logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
    logic [DATA_WIDTH-1:0]  cell_next [DEPTH];
    logic [DATA_WIDTH-1:0]  rd_bus    [DEPTH+1];
    logic [DATA_WIDTH-1:0]  bk_bus    [DEPTH+1];

    logic                   out_valid_reg;
    logic [DATA_WIDTH-1:0]  read_value_reg;
    logic [POS_WIDTH-1:0]   entry_count_reg;
    logic [DATA_WIDTH-1:0]  front_value_reg;
    logic [DATA_WIDTH-1:0]  back_value_reg;
    logic                   empty_res_reg;
    logic [1:0]             status_reg;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;

    isa_ctrl #(
        .DEPTH     (DEPTH),
        .POS_WIDTH (POS_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .kind      (req.kind),
        .position  (req.position),
        .cmd       (cmd),
        .shift_pos (shift_pos),
        .held_next (held_next),
        .status    (status)
    );

    assign rd_bus[0] = '0;
    assign bk_bus[0] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = req.value;
        end
        else
        begin : g_left
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = '0;
        end
        else
        begin : g_right
            assign right_data = cell_data[i+1];
        end

        isa_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .POS_WIDTH  (POS_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .shift_pos  (shift_pos),
            .held_next  (held_next),
            .value      (req.value),
            .left_data  (left_data),
            .right_data (right_data),
            .rd_in      (rd_bus[i]),
            .bk_in      (bk_bus[i]),
            .data       (cell_data[i]),
            .data_nx    (cell_next[i]),
            .rd_out     (rd_bus[i+1]),
            .bk_out     (bk_bus[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            read_value_reg  <= rd_bus[DEPTH];
            entry_count_reg <= held_next;
            front_value_reg <= (held_next != '0) ? cell_next[0] : '0;
            back_value_reg  <= bk_bus[DEPTH];
            empty_res_reg   <= (held_next == '0);
            status_reg      <= status;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.entry_count = entry_count_reg;
    assign rsp.front_value = front_value_reg;
    assign rsp.back_value  = back_value_reg;
    assign rsp.empty_res   = empty_res_reg;
    assign rsp.status      = status_reg;

    `ISA_ASSERT_NXT(a_fire_shows, fire, out_valid_reg, "accepted transaction produced no result")
    `ISA_ASSERT(a_no_overwrite, out_valid_reg && !rsp.ready, !req.ready, "pending result could be overwritten")

endmodule
